### rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the pattern unpacker
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tpu_pkg.sv
// types, constants and register codes of the tracker pattern unpacker
// no dependencies; imported by every module of the block
package tpu_pkg;

	localparam int unsigned TPU_MAX_ROWS      = 256;
	localparam int unsigned TPU_MAX_STORED_CH = 32;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ROW_W      = 16;
	localparam int unsigned CH_W       = 8;
	localparam int unsigned FIELD_CNT  = 5;
	localparam int unsigned TDATA_W    = 72;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 16;

	// descriptor decoding
	localparam int unsigned          DESC_FLAG_BIT   = 7;
	localparam logic [FIELD_CNT-1:0] MASK_AFTER_NOTE = 5'h1E;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 8'd1;

	localparam logic [ROW_W-1:0] RESET_SOURCE_ROWS   = 16'd64;
	localparam logic [CH_W-1:0]  RESET_CHANNEL_COUNT = 8'd32;

	typedef enum logic {
		KIND_CELL = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef enum logic {
		STATUS_COMPLETE  = 1'b0,
		STATUS_TRUNCATED = 1'b1
	} status_t;

	typedef struct packed {
		logic [ROW_W-1:0] source_rows;
		logic [CH_W-1:0]  channel_count;
	} cfg_t;

	// cell_bytes[0] note, [1] instrument, [2] volume, [3] effect, [4] parameter
	typedef struct packed {
		kind_t                             kind;
		logic [ROW_W-1:0]                  row_index;
		logic [CH_W-1:0]                   channel_index;
		logic [FIELD_CNT-1:0][BYTE_W-1:0]  cell_bytes;
		logic                              stored;
		status_t                           status;
		logic                              last_result;
	} result_t;

endpackage

### rtl/core/tpu_parser.sv
// byte parser of the pattern unpacker: cell assembly and row/channel position
// depends on tpu_pkg
module tpu_parser import tpu_pkg::*; #(
	parameter int unsigned MAX_ROWS      = TPU_MAX_ROWS,
	parameter int unsigned MAX_STORED_CH = TPU_MAX_STORED_CH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              en,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output logic [1:0]        res_cnt,
	output result_t           res_a,
	output result_t           res_b
);

	localparam logic [ROW_W-1:0] MAX_ROWS_L = ROW_W'(MAX_ROWS);
	localparam logic [CH_W-1:0]  MAX_CH_L   = CH_W'(MAX_STORED_CH);

	logic [FIELD_CNT-1:0]             mask_q, mask_nx;
	logic                             in_cell_q, in_cell_nx;
	logic [FIELD_CNT-1:0][BYTE_W-1:0] part_q, part_fill, part_nx;
	logic [ROW_W-1:0]                 row_q, row_nx, row_inc;
	logic [CH_W-1:0]                  ch_q, ch_nx, ch_inc;
	logic                             done_q, done_nx;
	logic                             accepting, finished, complete;
	result_t                          cell_res, end_res;

	assign ch_inc  = ch_q + CH_W'(1);
	assign row_inc = row_q + ROW_W'(1);

	always_comb begin
		accepting  = !done_q && (cfg.channel_count != '0) && (row_q < cfg.source_rows);
		mask_nx    = mask_q;
		in_cell_nx = in_cell_q;
		part_fill  = part_q;
		row_nx     = row_q;
		ch_nx      = ch_q;
		done_nx    = done_q;
		finished   = 1'b0;
		if (accepting) begin
			if (!in_cell_q) begin
				part_fill = '0;
				if (data_byte[DESC_FLAG_BIT]) begin
					mask_nx = data_byte[FIELD_CNT-1:0];
					if (mask_nx == '0) begin
						finished = 1'b1;
					end else begin
						in_cell_nx = 1'b1;
					end
				end else begin
					part_fill[0] = data_byte;
					mask_nx      = MASK_AFTER_NOTE;
					in_cell_nx   = 1'b1;
				end
			end else begin
				// lowest pending field takes the byte
				if (mask_q[0]) begin
					part_fill[0] = data_byte;
					mask_nx[0]   = 1'b0;
				end else if (mask_q[1]) begin
					part_fill[1] = data_byte;
					mask_nx[1]   = 1'b0;
				end else if (mask_q[2]) begin
					part_fill[2] = data_byte;
					mask_nx[2]   = 1'b0;
				end else if (mask_q[3]) begin
					part_fill[3] = data_byte;
					mask_nx[3]   = 1'b0;
				end else if (mask_q[4]) begin
					part_fill[4] = data_byte;
					mask_nx[4]   = 1'b0;
				end
				if (mask_nx == '0) begin
					finished = 1'b1;
				end
			end
		end
		if (finished) begin
			mask_nx    = '0;
			in_cell_nx = 1'b0;
			if ((ch_inc >= cfg.channel_count) || (ch_inc == '0)) begin
				ch_nx  = '0;
				row_nx = row_inc;
				if ((row_inc >= cfg.source_rows) || (row_inc == '0)) begin
					done_nx = 1'b1;
				end
			end else begin
				ch_nx = ch_inc;
			end
		end
		part_nx = finished ? '0 : part_fill;
	end

	always_comb begin
		complete = (cfg.channel_count != '0) && (done_nx || (row_nx >= cfg.source_rows));

		cell_res               = '0;
		cell_res.kind          = KIND_CELL;
		cell_res.row_index     = row_q;
		cell_res.channel_index = ch_q;
		cell_res.cell_bytes    = part_fill;
		cell_res.stored        = (row_q < MAX_ROWS_L) && (ch_q < MAX_CH_L);
		cell_res.status        = STATUS_COMPLETE;
		cell_res.last_result   = !last_byte;

		end_res             = '0;
		end_res.kind        = KIND_END;
		end_res.status      = complete ? STATUS_COMPLETE : STATUS_TRUNCATED;
		end_res.last_result = 1'b1;

		res_cnt = {1'b0, finished} + {1'b0, last_byte};
		res_a   = finished ? cell_res : end_res;
		res_b   = end_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			in_cell_q <= 1'b0;
			part_q    <= '0;
			row_q     <= '0;
			ch_q      <= '0;
			done_q    <= 1'b0;
		end else if (en) begin
			if (last_byte) begin
				mask_q    <= '0;
				in_cell_q <= 1'b0;
				part_q    <= '0;
				row_q     <= '0;
				ch_q      <= '0;
				done_q    <= 1'b0;
			end else begin
				mask_q    <= mask_nx;
				in_cell_q <= in_cell_nx;
				part_q    <= part_nx;
				row_q     <= row_nx;
				ch_q      <= ch_nx;
				done_q    <= done_nx;
			end
		end
	end

endmodule

### rtl/core/tpu_res_fifo.sv
// two-entry result queue of the pattunpacker output, takes up to two results a cycle
// depends on tpu_pkg
module tpu_res_fifo import tpu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  result_t    push_a,
	input  result_t    push_b,
	input  logic       pop,
	output logic [1:0] room,
	output logic       out_valid,
	output result_t    out_res
);

	result_t    ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = ent_q[rd_ptr_q];
	// slots free this cycle, counting the one being drained
	assign room      = 2'd2 - cnt_q + {1'b0, pop};

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			ent_q[wr_ptr_q] <= push_a;
		end
		if (push_cnt == 2'd2) begin
			ent_q[~wr_ptr_q] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q ^ push_cnt[0];
			rd_ptr_q <= rd_ptr_q ^ pop;
			cnt_q    <= cnt_q + push_cnt - {1'b0, pop};
		end
	end

endmodule

### rtl/core/tracker_pattern_unpacker.sv
// tracker pattern unpacker top level: input register, parser, result queue
// path: a byte is registered in the input stage, then its results are registered in the result queue
// throughput: one byte per cycle while the result queue has room; a byte that yields a cell and an end status
// sends its two results out one after the other, bounded by the single output port
// reset: asynchronous active low; parser state cleared, source_rows 64, channel_count 32
// depends on tpu_pkg, tpu_parser, tpu_res_fifo, assert_macros.svh
`include "assert_macros.svh"

module tracker_pattern_unpacker import tpu_pkg::*; #(
	parameter int unsigned MAX_ROWS      = TPU_MAX_ROWS,
	parameter int unsigned MAX_STORED_CH = TPU_MAX_STORED_CH
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// packed pattern bytes
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  logic                  s_axis_tlast,  // last_byte

	// decoded cells and end status
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [15:0] row_index, [23:16] channel_index, [31:24] note_value,
	// [39:32] instrument, [47:40] volume_column, [55:48] effect_type,
	// [63:56] effect_param, [64] stored, [65] status, [71:66] zero
	output logic [TDATA_W-1:0]    m_axis_tdata,
	output logic                  m_axis_tuser,  // kind
	output logic                  m_axis_tlast,  // last_result

	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [ROW_W-1:0] MAX_ROWS_L = ROW_W'(MAX_ROWS);
	localparam logic [CH_W-1:0]  MAX_CH_L   = CH_W'(MAX_STORED_CH);
	localparam int unsigned      PAD_W      = TDATA_W - ROW_W - CH_W - FIELD_CNT * BYTE_W - 2;

	// configuration registers
	logic [ROW_W-1:0] source_rows_q;
	logic [CH_W-1:0]  channel_count_q;
	cfg_t             cfg;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;

	logic       in_accept, proc, pop;
	logic [1:0] res_cnt, room;
	result_t    res_a, res_b, out_res;

	// terms of the checks at the end
	logic            s1_stall, out_end, end_zero, out_stored, stored_in_range;
	logic [BYTE_W:0] s1_item;

	// writes always taken; an unknown index is dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_rows_q   <= RESET_SOURCE_ROWS;
			channel_count_q <= RESET_CHANNEL_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SOURCE_ROWS:   source_rows_q   <= cfg_data[ROW_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CH_W-1:0];
				default:           ;
			endcase
		end
	end

	assign cfg.source_rows   = source_rows_q;
	assign cfg.channel_count = channel_count_q;

	// the byte in the input stage moves on once the queue has room for all its results; room counts
	// the slot freed by this cycle's pop, so the stream keeps one byte a cycle while the queue has room
	assign proc          = valid_s1 && ({1'b0, res_cnt} <= {1'b0, room});
	assign s_axis_tready = !valid_s1 || proc;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// parser: descriptor/field decode, cell position, end status
	tpu_parser #(
		.MAX_ROWS      (MAX_ROWS),
		.MAX_STORED_CH (MAX_STORED_CH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.en        (proc),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res_cnt   (res_cnt),
		.res_a     (res_a),
		.res_b     (res_b)
	);

	// result queue doubles as the output register
	assign pop = m_axis_tvalid && m_axis_tready;

	tpu_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (proc ? res_cnt : 2'd0),
		.push_a    (res_a),
		.push_b    (res_b),
		.pop       (pop),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {PAD_W'(0), out_res.status, out_res.stored, out_res.cell_bytes,
		out_res.channel_index, out_res.row_index};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last_result;

	assign s1_stall        = valid_s1 && !proc;
	assign s1_item         = {last_s1, data_s1};
	assign out_end         = m_axis_tvalid && (out_res.kind == KIND_END);
	assign end_zero        = (out_res.row_index == '0) && (out_res.channel_index == '0) &&
		!out_res.stored;
	assign out_stored      = m_axis_tvalid && out_res.stored;
	assign stored_in_range = (out_res.row_index < MAX_ROWS_L) && (out_res.channel_index < MAX_CH_L);

	// a byte held back in the input stage keeps its contents
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_stall, valid_s1 && $stable(s1_item), "held item changed")
	// end status carries no position
	`ASSERT_IMPLIES(a_end_clean, clk, arst_n, out_end, end_zero, "end status with cell fields set")
	// stored flag only inside the kept window
	`ASSERT_IMPLIES(a_stored_range, clk, arst_n, out_stored, stored_in_range, "stored out of range")

endmodule
